// File: src/two_variable_sweep_solver_unit_defines.svh
// Assertion macros for the sweep solver.
`ifndef TWO_VARIABLE_SWEEP_SOLVER_UNIT_DEFINES_SVH
`define TWO_VARIABLE_SWEEP_SOLVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TVS_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvs: implication check failed");
`define TVS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvs: next-cycle check failed");
`else
`define TVS_ASSERT_IMPLY(name, ante, cons)
`define TVS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: src/tvs_pkg.sv
package tvs_pkg;

    localparam int SLICE_W = 6;
    localparam int REG_AW  = 5;
    localparam int PC_W    = 7;

    // position codes
    localparam logic [1:0] POS_INNER  = 2'd0;
    localparam logic [1:0] POS_TOP    = 2'd1;
    localparam logic [1:0] POS_BOTTOM = 2'd2;
    localparam logic [1:0] POS_NONE   = 2'd3;

    // micro-op codes
    localparam logic [3:0] OP_MUL   = 4'd0;
    localparam logic [3:0] OP_DIV   = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_LDM   = 4'd4;
    localparam logic [3:0] OP_RDM   = 4'd5;
    localparam logic [3:0] OP_STORE = 4'd6;
    localparam logic [3:0] OP_SKIPZ = 4'd7;
    localparam logic [3:0] OP_EMIT  = 4'd8;

    // stored-word selects for OP_LDM
    localparam logic [REG_AW-1:0] MS_Q1  = 5'd0;
    localparam logic [REG_AW-1:0] MS_Q2  = 5'd1;
    localparam logic [REG_AW-1:0] MS_Q3  = 5'd2;
    localparam logic [REG_AW-1:0] MS_K1  = 5'd3;
    localparam logic [REG_AW-1:0] MS_K2  = 5'd4;
    localparam logic [REG_AW-1:0] MS_TOP = 5'd5;

    // scratch register file map; 0..13 are loaded from the item
    localparam logic [REG_AW-1:0] R_A1  = 5'd0;
    localparam logic [REG_AW-1:0] R_A2  = 5'd1;
    localparam logic [REG_AW-1:0] R_A3  = 5'd2;
    localparam logic [REG_AW-1:0] R_A4  = 5'd3;
    localparam logic [REG_AW-1:0] R_B1  = 5'd4;
    localparam logic [REG_AW-1:0] R_B2  = 5'd5;
    localparam logic [REG_AW-1:0] R_B3  = 5'd6;
    localparam logic [REG_AW-1:0] R_B4  = 5'd7;
    localparam logic [REG_AW-1:0] R_KK  = 5'd8;
    localparam logic [REG_AW-1:0] R_LL  = 5'd9;
    localparam logic [REG_AW-1:0] R_VB  = 5'd10;
    localparam logic [REG_AW-1:0] R_ONE = 5'd11;
    localparam logic [REG_AW-1:0] R_K1P = 5'd12;
    localparam logic [REG_AW-1:0] R_K2P = 5'd13;
    localparam logic [REG_AW-1:0] R_T0  = 5'd14;
    localparam logic [REG_AW-1:0] R_T1  = 5'd15;
    localparam logic [REG_AW-1:0] R_W1  = 5'd16;
    localparam logic [REG_AW-1:0] R_W2  = 5'd17;
    localparam logic [REG_AW-1:0] R_W3  = 5'd18;
    localparam logic [REG_AW-1:0] R_W4  = 5'd19;
    localparam logic [REG_AW-1:0] R_Q1  = 5'd20;
    localparam logic [REG_AW-1:0] R_Q2  = 5'd21;
    localparam logic [REG_AW-1:0] R_Q3  = 5'd22;
    localparam logic [REG_AW-1:0] R_M1  = 5'd23;
    localparam logic [REG_AW-1:0] R_M2  = 5'd24;
    localparam logic [REG_AW-1:0] R_M3  = 5'd25;
    localparam logic [REG_AW-1:0] R_P   = 5'd26;
    localparam logic [REG_AW-1:0] R_D   = 5'd27;
    localparam logic [REG_AW-1:0] R_K1  = 5'd28;
    localparam logic [REG_AW-1:0] R_K2  = 5'd29;
    localparam logic [REG_AW-1:0] R_H   = 5'd30;
    localparam logic [REG_AW-1:0] R_V   = 5'd31;

    localparam logic [PC_W-1:0] PC_LOOP = 7'd50;
    localparam logic [PC_W-1:0] PC_VTOP = 7'd64;

    typedef struct packed {
        logic [3:0]        op;
        logic [REG_AW-1:0] dst;
        logic [REG_AW-1:0] a;
        logic [REG_AW-1:0] b;
        logic [PC_W-1:0]   tgt;
    } uop_t;

    function automatic uop_t mk(input logic [3:0] op, input logic [REG_AW-1:0] dst,
                                input logic [REG_AW-1:0] a, input logic [REG_AW-1:0] b);
        uop_t u;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        u.tgt = '0;
        return u;
    endfunction

    // Forward sweep (0..44), bottom fix (45..49), per-slice back sweep (50..65).
    // Top items run the same program with K1p = 0 and K2p = boundary velocity.
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(OP_EMIT, R_T0, R_H, R_V);
        unique case (pc)
            7'd0:  u = mk(OP_MUL, R_T0, R_B3, R_A1);
            7'd1:  u = mk(OP_DIV, R_T0, R_T0, R_A3);
            7'd2:  u = mk(OP_SUB, R_T0, R_B1, R_T0);
            7'd3:  u = mk(OP_DIV, R_W2, R_ONE, R_T0);
            7'd4:  u = mk(OP_MUL, R_T0, R_W2, R_A1);
            7'd5:  u = mk(OP_DIV, R_W1, R_T0, R_A3);
            7'd6:  u = mk(OP_MUL, R_T0, R_A4, R_B2);
            7'd7:  u = mk(OP_DIV, R_T0, R_T0, R_B4);
            7'd8:  u = mk(OP_SUB, R_T0, R_A2, R_T0);
            7'd9:  u = mk(OP_DIV, R_W4, R_ONE, R_T0);
            7'd10: u = mk(OP_MUL, R_T0, R_W4, R_B2);
            7'd11: u = mk(OP_DIV, R_W3, R_T0, R_B4);
            7'd12: u = mk(OP_MUL, R_T0, R_A4, R_W1);
            7'd13: u = mk(OP_MUL, R_T1, R_A2, R_W2);
            7'd14: u = mk(OP_SUB, R_Q1, R_T0, R_T1);
            7'd15: u = mk(OP_MUL, R_T0, R_B4, R_W1);
            7'd16: u = mk(OP_MUL, R_T1, R_B2, R_W2);
            7'd17: u = mk(OP_SUB, R_Q2, R_T0, R_T1);
            7'd18: u = mk(OP_MUL, R_T0, R_LL, R_W1);
            7'd19: u = mk(OP_MUL, R_T1, R_KK, R_W2);
            7'd20: u = mk(OP_SUB, R_Q3, R_T0, R_T1);
            7'd21: u = mk(OP_MUL, R_T0, R_A3, R_W3);
            7'd22: u = mk(OP_MUL, R_T1, R_A1, R_W4);
            7'd23: u = mk(OP_SUB, R_M1, R_T0, R_T1);
            7'd24: u = mk(OP_MUL, R_T0, R_B3, R_W3);
            7'd25: u = mk(OP_MUL, R_T1, R_B1, R_W4);
            7'd26: u = mk(OP_SUB, R_M2, R_T0, R_T1);
            7'd27: u = mk(OP_MUL, R_T0, R_LL, R_W3);
            7'd28: u = mk(OP_MUL, R_T1, R_KK, R_W4);
            7'd29: u = mk(OP_SUB, R_M3, R_T0, R_T1);
            7'd30: u = mk(OP_MUL, R_T0, R_K1P, R_M1);
            7'd31: u = mk(OP_ADD, R_P, R_T0, R_M2);
            7'd32: u = mk(OP_MUL, R_T0, R_K1P, R_Q1);
            7'd33: u = mk(OP_MUL, R_T0, R_T0, R_M1);
            7'd34: u = mk(OP_SUB, R_T1, R_ONE, R_T0);
            7'd35: u = mk(OP_MUL, R_T0, R_Q1, R_M2);
            7'd36: u = mk(OP_SUB, R_D, R_T1, R_T0);
            7'd37: u = mk(OP_MUL, R_T0, R_Q2, R_P);
            7'd38: u = mk(OP_DIV, R_K1, R_T0, R_D);
            7'd39: u = mk(OP_MUL, R_T0, R_Q3, R_P);
            7'd40: u = mk(OP_MUL, R_T1, R_K2P, R_M1);
            7'd41: u = mk(OP_ADD, R_T0, R_T0, R_T1);
            7'd42: u = mk(OP_ADD, R_T0, R_T0, R_M3);
            7'd43: u = mk(OP_DIV, R_K2, R_T0, R_D);
            7'd44: u = mk(OP_STORE, R_T0, R_K1, R_K2);
            7'd45: u = mk(OP_SUB, R_T0, R_VB, R_K2);
            7'd46: u = mk(OP_DIV, R_H, R_T0, R_K1);
            7'd47: u = mk(OP_SUB, R_T1, R_VB, R_VB);
            7'd48: u = mk(OP_ADD, R_V, R_VB, R_T1);
            7'd49: u = mk(OP_EMIT, R_T0, R_H, R_V);
            7'd50: u = mk(OP_RDM, R_T0, R_H, R_V);
            7'd51: u = mk(OP_LDM, R_W1, MS_Q1, R_T0);
            7'd52: u = mk(OP_LDM, R_W2, MS_Q2, R_T0);
            7'd53: u = mk(OP_LDM, R_W3, MS_Q3, R_T0);
            7'd54: u = mk(OP_LDM, R_W4, MS_K1, R_T0);
            7'd55: u = mk(OP_LDM, R_M1, MS_K2, R_T0);
            7'd56: u = mk(OP_MUL, R_T0, R_V, R_W1);
            7'd57: u = mk(OP_MUL, R_T1, R_H, R_W2);
            7'd58: u = mk(OP_ADD, R_T0, R_T0, R_T1);
            7'd59: u = mk(OP_ADD, R_H, R_T0, R_W3);
            7'd60:
            begin
                u     = mk(OP_SKIPZ, R_T0, R_T0, R_T0);
                u.tgt = PC_VTOP;
            end
            7'd61: u = mk(OP_MUL, R_T0, R_W4, R_H);
            7'd62: u = mk(OP_ADD, R_V, R_T0, R_M1);
            7'd63: u = mk(OP_EMIT, R_T0, R_H, R_V);
            7'd64: u = mk(OP_LDM, R_V, MS_TOP, R_T0);
            7'd65: u = mk(OP_EMIT, R_T0, R_H, R_V);
            default: u = mk(OP_EMIT, R_T0, R_H, R_V);
        endcase
        return u;
    endfunction

endpackage

// File: src/tvs_if.sv
interface tvs_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] coef_a1;
    logic signed [DATA_WIDTH-1:0] coef_a2;
    logic signed [DATA_WIDTH-1:0] coef_a3;
    logic signed [DATA_WIDTH-1:0] coef_a4;
    logic signed [DATA_WIDTH-1:0] coef_b1;
    logic signed [DATA_WIDTH-1:0] coef_b2;
    logic signed [DATA_WIDTH-1:0] coef_b3;
    logic signed [DATA_WIDTH-1:0] coef_b4;
    logic signed [DATA_WIDTH-1:0] coef_k;
    logic signed [DATA_WIDTH-1:0] coef_l;
    logic        [1:0]            position;
    logic signed [DATA_WIDTH-1:0] boundary_value;

    modport source (
        output valid, coef_a1, coef_a2, coef_a3, coef_a4, coef_b1, coef_b2, coef_b3,
               coef_b4, coef_k, coef_l, position, boundary_value,
        input  ready
    );
    modport sink (
        input  valid, coef_a1, coef_a2, coef_a3, coef_a4, coef_b1, coef_b2, coef_b3,
               coef_b4, coef_k, coef_l, position, boundary_value,
        output ready
    );
endinterface

interface tvs_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic        [5:0]            slice_index;
    logic signed [DATA_WIDTH-1:0] level;
    logic signed [DATA_WIDTH-1:0] velocity;
    logic                         last_of_run;

    modport source (
        output valid, slice_index, level, velocity, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, slice_index, level, velocity, last_of_run,
        output ready
    );
endinterface

// File: src/two_variable_sweep_solver_unit.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    coef_a1..a4, coef_b1..b4, coef_k, coef_l, position,
//                               boundary_value
// out_ch    out  valid/ready    slice_index, level, velocity, last_of_run
//
// One item at a time; in_ch.ready is high only while idle.
// All arithmetic runs through one shared unit: a bit-serial multiplier (DATA_WIDTH steps)
// and a restoring divider (DATA_WIDTH+FRACTION_BITS steps), plus add/sub.
// Forward item: load, then the forward sweep and store. Bottom item adds the bottom-slice fix
// with one divide, then a back-sweep pass per slice (2 multiplies on the top slice).
// Output stalls hold the sequencer on the emit step. rst_n clears control state only.
`include "two_variable_sweep_solver_unit_defines.svh"

module two_variable_sweep_solver_unit #(
    parameter int MAX_INTERVALS = 63,
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    tvs_in_if.sink   in_ch,
    tvs_out_if.source out_ch
);
    import tvs_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int DVW = DW + F;
    localparam int RW = (2 * DW - F > DW + F) ? 2 * DW - F : DW + F;
    localparam int MUL_STEPS = DW;
    localparam int DIV_STEPS = DW + F;
    localparam int IW = $clog2(DIV_STEPS + 1);

    localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE_VAL = (F >= DW - 1) ? VMAX : DW'(64'd1 << F);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    function automatic logic [DW-1:0] fx_mag(input logic [DW-1:0] x);
        return x[DW-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [DW-1:0] fx_sat(input logic neg, input logic [RW-1:0] mag);
        logic [RW-1:0] half_w;
        logic [DW-1:0] lo;
        half_w = RW'(1) << (DW - 1);
        lo     = mag[DW-1:0];
        if (neg)
            return (mag >= half_w) ? VMIN : (~lo + 1'b1);
        return (mag >= half_w) ? VMAX : lo;
    endfunction

    function automatic logic [DW-1:0] fx_addsub(input logic [DW-1:0] x,
                                                input logic [DW-1:0] y, input logic sub);
        logic [DW:0] s;
        if (sub)
            s = {x[DW-1], x} - {y[DW-1], y};
        else
            s = {x[DW-1], x} + {y[DW-1], y};
        if (s[DW] != s[DW-1])
            return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    // control
    logic [2:0]      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [3:0]      ld_idx_reg, ld_idx_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   slice_reg, slice_next;
    logic [DW-1:0]   top_vel_reg, top_vel_next;
    logic            out_valid_reg, out_valid_next;
    logic [IW-1:0]   iter_reg, iter_next;
    logic            is_div_reg, is_div_next;

    // payload and unit registers
    logic [DW-1:0]   coef_reg [10];
    logic [1:0]      pos_reg;
    logic [DW-1:0]   vb_reg;
    logic [DW-1:0]   kp1_reg, kp2_reg;
    logic [DW-1:0]   q1m_reg, q2m_reg, q3m_reg, k1m_reg, k2m_reg;
    logic [2*DW-1:0] prod_reg, prod_next;
    logic [DW-1:0]   opd_reg, opd_next;
    logic            neg_reg, neg_next;
    logic [DVW-1:0]  dvd_reg, dvd_next;
    logic [DW:0]     rem_reg, rem_next;
    logic [DVW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]   lvl_reg, vel_reg;
    logic [SLICE_W-1:0] slc_reg;
    logic            last_reg;

    // scratch and stores
    logic [DW-1:0]   scratch_mem [32];
    logic [DW-1:0]   rd_a_reg, rd_b_reg;
    logic [DW-1:0]   q1_mem [MAX_INTERVALS];
    logic [DW-1:0]   q2_mem [MAX_INTERVALS];
    logic [DW-1:0]   q3_mem [MAX_INTERVALS];
    logic [DW-1:0]   k1_mem [MAX_INTERVALS];
    logic [DW-1:0]   k2_mem [MAX_INTERVALS];
    logic [DW-1:0]   mq1_reg, mq2_reg, mq3_reg, mk1_reg, mk2_reg;

    uop_t            uop;
    logic            accept_in, ignore_in, is_top;
    logic            sc_we;
    logic [REG_AW-1:0] sc_waddr;
    logic [DW-1:0]   sc_wdata, ld_data;
    logic            st_we, rd_en;
    logic [CW-1:0]   st_idx, slice_dec;
    logic [DW:0]     mul_sum, div_r2;
    logic            div_ge;
    logic [DW-1:0]   mag_a, mag_b;

    assign uop       = ucode(pc_reg);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept_in = in_ch.valid && in_ch.ready;
    assign ignore_in = (in_ch.position == POS_NONE) ||
                       ((in_ch.position != POS_TOP) && (count_reg >= CW'(MAX_INTERVALS)));
    assign is_top    = (pos_reg == POS_TOP);
    assign st_idx    = is_top ? '0 : count_reg;
    assign slice_dec = slice_reg - 1'b1;
    assign mag_a     = fx_mag(rd_a_reg);
    assign mag_b     = fx_mag(rd_b_reg);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.slice_index = slc_reg;
    assign out_ch.level       = lvl_reg;
    assign out_ch.velocity    = vel_reg;
    assign out_ch.last_of_run = last_reg;

    // shared unit step
    assign mul_sum = {1'b0, prod_reg[2*DW-1:DW]} + (prod_reg[0] ? {1'b0, opd_reg} : '0);
    assign div_r2  = {rem_reg[DW-1:0], dvd_reg[DVW-1]};
    assign div_ge  = div_r2 >= {1'b0, opd_reg};

    always_comb
    begin
        unique case (ld_idx_reg)
            R_A1[3:0]:  ld_data = coef_reg[0];
            R_A2[3:0]:  ld_data = coef_reg[1];
            R_A3[3:0]:  ld_data = coef_reg[2];
            R_A4[3:0]:  ld_data = coef_reg[3];
            R_B1[3:0]:  ld_data = coef_reg[4];
            R_B2[3:0]:  ld_data = coef_reg[5];
            R_B3[3:0]:  ld_data = coef_reg[6];
            R_B4[3:0]:  ld_data = coef_reg[7];
            R_KK[3:0]:  ld_data = coef_reg[8];
            R_LL[3:0]:  ld_data = coef_reg[9];
            R_VB[3:0]:  ld_data = vb_reg;
            R_ONE[3:0]: ld_data = ONE_VAL;
            R_K1P[3:0]: ld_data = (is_top || count_reg == '0) ? '0 : kp1_reg;
            R_K2P[3:0]: ld_data = is_top ? vb_reg : ((count_reg == '0) ? '0 : kp2_reg);
            default:    ld_data = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        ld_idx_next    = ld_idx_reg;
        count_next     = count_reg;
        slice_next     = slice_reg;
        top_vel_next   = top_vel_reg;
        out_valid_next = out_valid_reg;
        iter_next      = iter_reg;
        is_div_next    = is_div_reg;
        prod_next      = prod_reg;
        opd_next       = opd_reg;
        neg_next       = neg_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        sc_we          = 1'b0;
        sc_waddr       = uop.dst;
        sc_wdata       = '0;
        st_we          = 1'b0;
        rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in && !ignore_in)
                begin
                    state_next  = ST_LOAD;
                    ld_idx_next = '0;
                    if (in_ch.position == POS_TOP)
                        top_vel_next = in_ch.boundary_value;
                end
            end
            ST_LOAD:
            begin
                sc_we       = 1'b1;
                sc_waddr    = REG_AW'(ld_idx_reg);
                sc_wdata    = ld_data;
                ld_idx_next = ld_idx_reg + 1'b1;
                if (ld_idx_reg == R_K2P[3:0])
                begin
                    state_next = ST_FETCH;
                    pc_next    = '0;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_FETCH;
                pc_next    = pc_reg + 1'b1;
                unique case (uop.op)
                    OP_ADD, OP_SUB:
                    begin
                        sc_we    = 1'b1;
                        sc_wdata = fx_addsub(rd_a_reg, rd_b_reg, uop.op == OP_SUB);
                    end
                    OP_MUL:
                    begin
                        state_next  = ST_RUN;
                        pc_next     = pc_reg;
                        is_div_next = 1'b0;
                        iter_next   = '0;
                        opd_next    = mag_a;
                        prod_next   = {{DW{1'b0}}, mag_b};
                        neg_next    = rd_a_reg[DW-1] ^ rd_b_reg[DW-1];
                    end
                    OP_DIV:
                    begin
                        if (rd_b_reg == '0)
                        begin
                            // divide by zero saturates on the dividend's sign
                            sc_we    = 1'b1;
                            sc_wdata = rd_a_reg[DW-1] ? VMIN : VMAX;
                        end
                        else
                        begin
                            state_next  = ST_RUN;
                            pc_next     = pc_reg;
                            is_div_next = 1'b1;
                            iter_next   = '0;
                            opd_next    = mag_b;
                            dvd_next    = {mag_a, {F{1'b0}}};
                            rem_next    = '0;
                            quo_next    = '0;
                            neg_next    = rd_a_reg[DW-1] ^ rd_b_reg[DW-1];
                        end
                    end
                    OP_LDM:
                    begin
                        sc_we = 1'b1;
                        unique case (uop.a)
                            MS_Q1:   sc_wdata = mq1_reg;
                            MS_Q2:   sc_wdata = mq2_reg;
                            MS_Q3:   sc_wdata = mq3_reg;
                            MS_K1:   sc_wdata = mk1_reg;
                            MS_K2:   sc_wdata = mk2_reg;
                            default: sc_wdata = top_vel_reg;
                        endcase
                    end
                    OP_RDM:
                    begin
                        rd_en = 1'b1;
                    end
                    OP_STORE:
                    begin
                        st_we      = 1'b1;
                        count_next = st_idx + 1'b1;
                        slice_next = st_idx + 1'b1;
                        if (pos_reg != POS_BOTTOM)
                            state_next = ST_IDLE;
                    end
                    OP_SKIPZ:
                    begin
                        if (slice_reg == '0)
                            pc_next = uop.tgt;
                    end
                    OP_EMIT:
                    begin
                        state_next     = ST_EMIT;
                        pc_next        = pc_reg;
                        out_valid_next = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RUN:
            begin
                if (is_div_reg ? (iter_reg == IW'(DIV_STEPS)) : (iter_reg == IW'(MUL_STEPS)))
                begin
                    sc_we      = 1'b1;
                    sc_wdata   = is_div_reg ? fx_sat(neg_reg, RW'(quo_reg))
                                            : fx_sat(neg_reg, RW'(prod_reg >> F));
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_FETCH;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                    if (is_div_reg)
                    begin
                        rem_next = div_ge ? (div_r2 - {1'b0, opd_reg}) : div_r2;
                        quo_next = {quo_reg[DVW-2:0], div_ge};
                        dvd_next = dvd_reg << 1;
                    end
                    else
                    begin
                        prod_next = {mul_sum, prod_reg[DW-1:1]};
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    if (slice_reg == '0)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        slice_next = slice_dec;
                        pc_next    = PC_LOOP;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            ld_idx_reg    <= '0;
            count_reg     <= '0;
            slice_reg     <= '0;
            top_vel_reg   <= '0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            is_div_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            ld_idx_reg    <= ld_idx_next;
            count_reg     <= count_next;
            slice_reg     <= slice_next;
            top_vel_reg   <= top_vel_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            is_div_reg    <= is_div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            coef_reg[0] <= in_ch.coef_a1;
            coef_reg[1] <= in_ch.coef_a2;
            coef_reg[2] <= in_ch.coef_a3;
            coef_reg[3] <= in_ch.coef_a4;
            coef_reg[4] <= in_ch.coef_b1;
            coef_reg[5] <= in_ch.coef_b2;
            coef_reg[6] <= in_ch.coef_b3;
            coef_reg[7] <= in_ch.coef_b4;
            coef_reg[8] <= in_ch.coef_k;
            coef_reg[9] <= in_ch.coef_l;
            pos_reg     <= in_ch.position;
            vb_reg      <= in_ch.boundary_value;
        end
        prod_reg <= prod_next;
        opd_reg  <= opd_next;
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        // shadow copies of the values that go to the stores
        if (sc_we)
        begin
            if (sc_waddr == R_Q1) q1m_reg <= sc_wdata;
            if (sc_waddr == R_Q2) q2m_reg <= sc_wdata;
            if (sc_waddr == R_Q3) q3m_reg <= sc_wdata;
            if (sc_waddr == R_K1) k1m_reg <= sc_wdata;
            if (sc_waddr == R_K2) k2m_reg <= sc_wdata;
        end
        if (st_we)
        begin
            kp1_reg <= k1m_reg;
            kp2_reg <= k2m_reg;
        end
        if (state_reg == ST_EXEC && uop.op == OP_EMIT)
        begin
            lvl_reg  <= rd_a_reg;
            vel_reg  <= rd_b_reg;
            slc_reg  <= SLICE_W'(slice_reg);
            last_reg <= (slice_reg == '0);
        end
    end

    // scratch register file: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (sc_we)
            scratch_mem[sc_waddr] <= sc_wdata;
        rd_a_reg <= scratch_mem[uop.a];
        rd_b_reg <= scratch_mem[uop.b];
    end

    // interval stores: q at slice, k at slice - 1
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            q1_mem[st_idx[AW-1:0]] <= q1m_reg;
            q2_mem[st_idx[AW-1:0]] <= q2m_reg;
            q3_mem[st_idx[AW-1:0]] <= q3m_reg;
            k1_mem[st_idx[AW-1:0]] <= k1m_reg;
            k2_mem[st_idx[AW-1:0]] <= k2m_reg;
        end
        if (rd_en)
        begin
            mq1_reg <= q1_mem[slice_reg[AW-1:0]];
            mq2_reg <= q2_mem[slice_reg[AW-1:0]];
            mq3_reg <= q3_mem[slice_reg[AW-1:0]];
            mk1_reg <= k1_mem[slice_dec[AW-1:0]];
            mk2_reg <= k2_mem[slice_dec[AW-1:0]];
        end
    end

    `TVS_ASSERT_IMPLY(a_ready_not_busy, in_ch.ready, !out_valid_reg)
    `TVS_ASSERT_IMPLY(a_last_top_slice, out_valid_reg && last_reg, slc_reg == '0)
    `TVS_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(MAX_INTERVALS))
    `TVS_ASSERT_NEXT(a_run_clears, out_ch.valid && out_ch.ready && out_ch.last_of_run,
                     count_reg == '0 && state_reg == ST_IDLE)

endmodule
